/* hdl/ship_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ship_pkg;

   localparam int NUM_SETS      = 2048;
   localparam int NUM_WAYS      = 16;
   localparam int TABLE_ENTRIES = 4096;
   localparam int SIG_BITS      = 6;

   localparam int SET_BITS   = $clog2(NUM_SETS);
   localparam int WAY_BITS   = $clog2(NUM_WAYS);
   localparam int CTR_BITS   = $clog2(TABLE_ENTRIES);
   localparam int ADDR_BITS  = 64;
   localparam int RUN_BITS   = 5;
   localparam int RRPV_BITS  = 2;
   localparam int REUSE_BITS = 2;

   localparam logic [RRPV_BITS-1:0]  RRPV_MAX     = 2'd3;
   localparam logic [RRPV_BITS-1:0]  MISS_DEPTH   = 2'd2;
   localparam logic [RRPV_BITS-1:0]  HIT_DEPTH    = 2'd0;
   localparam logic [RUN_BITS-1:0]   RUN_MAX      = 5'd31;
   localparam logic [REUSE_BITS-1:0] CTR_MAX      = 2'd3;
   localparam logic [REUSE_BITS-1:0] STRONG_REUSE = 2'd2;
   localparam logic [REUSE_BITS-1:0] CTR_RESET    = 2'd1;
   localparam logic [RUN_BITS-1:0]   THRESH_RESET = 5'd8;

   localparam logic MODE_VICTIM = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   localparam int RRPV_ROW_BITS = NUM_WAYS * RRPV_BITS;
   localparam int SIG_ROW_BITS  = NUM_WAYS * SIG_BITS;

   typedef struct packed {
      logic [ADDR_BITS-1:0] prev_addr;
      logic [ADDR_BITS-1:0] prev_stride;
      logic [RUN_BITS-1:0]  run;
      logic                 streaming;
   } det_row_type;

   localparam int DET_ROW_BITS = $bits(det_row_type);

   function automatic logic [CTR_BITS-1:0] ctr_index(
      input logic [SIG_BITS-1:0] sig,
      input logic [SET_BITS-1:0] set_idx
   );
      logic [CTR_BITS-1:0] a;
      logic [CTR_BITS-1:0] b;
      a = CTR_BITS'(sig);
      b = CTR_BITS'(set_idx);
      return a ^ b;
   endfunction

endpackage
`default_nettype wire

/* hdl/ship_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ship_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/ship_stream_rrip_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none
// SHiP / SRRIP replacement engine for a 2048-set, 16-way cache.
// req channel: one transfer per access. tuser = mode (0 victim request,
// 1 update after access). tdata carries set, way, valid mask, hit,
// pc signature and address. rsp channel: exactly one transfer per
// request with the victim way (0 for updates) and the set's streaming flag.
// csr channel: writes the 5-bit stream threshold; always ready.
// Response path: rsp_tvalid rises after S_LOOK for victim requests, hits
// and streaming misses, after S_LOOK and S_DEC for non-streaming misses (extra
// read-modify-write of the evicted signature's counter on the single
// reuse-table port).
// One request in flight: req_tready is low until the response transfer.
// With the receiver ready, the request rate is set by the registered-read row
// memories and the one-port reuse table.
// Reset: a clearing pass walks the 4096-entry reuse table (and the 2048 set
// rows alongside) to their initial values; req_tready stays low meanwhile.
// csr writes are taken at any time.
// A stalled receiver holds the response; nothing else advances.
module ship_stream_rrip_replacement
   import ship_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // [10:0] set_index, [14:11] way, [30:15] valid_mask, [31] hit,
   // [37:32] pc_signature, [101:38] address, [103:102] zero
   input  wire logic [103:0] req_tdata,
   // [0] mode
   input  wire logic [0:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [3:0] victim_way, [4] set_streaming, [7:5] zero
   output      logic [7:0]   rsp_tdata,
   input  wire logic         csr_valid,
   output      logic         csr_ready,
   input  wire logic [4:0]   csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_DEC, S_OUT
   } state_type;

   state_type             state_ff;
   logic [CTR_BITS-1:0]   clr_ff;
   logic [RUN_BITS-1:0]   thresh_ff;
   logic                  mode_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [WAY_BITS-1:0]   way_ff;
   logic [NUM_WAYS-1:0]   mask_ff;
   logic                  hit_ff;
   logic [SIG_BITS-1:0]   sig_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [CTR_BITS-1:0]   idx_ff;
   logic [CTR_BITS-1:0]   old_idx_ff;
   logic [WAY_BITS-1:0]   victim_ff;
   logic                  stream_ff;

   // input unpacking
   logic [SET_BITS-1:0]  req_set;
   logic [SIG_BITS-1:0]  req_sig;
   assign req_set = req_tdata[10:0];
   assign req_sig = req_tdata[37:32];

   // memories
   logic                     rrpv_we;
   logic [SET_BITS-1:0]      rrpv_wa;
   logic [RRPV_ROW_BITS-1:0] rrpv_wd;
   logic [SET_BITS-1:0]      row_ra;
   logic [RRPV_ROW_BITS-1:0] rrpv_rd;
   logic                     sig_we;
   logic [SIG_ROW_BITS-1:0]  sig_wd;
   logic [SIG_ROW_BITS-1:0]  sig_rd;
   logic                     det_we;
   det_row_type              det_wd;
   logic [DET_ROW_BITS-1:0]  det_rd_bits;
   det_row_type              det_rd;
   logic                     reuse_we;
   logic [CTR_BITS-1:0]      reuse_wa;
   logic [REUSE_BITS-1:0]    reuse_wd;
   logic [CTR_BITS-1:0]      reuse_ra;
   logic [REUSE_BITS-1:0]    reuse_rd;

   assign det_rd = det_row_type'(det_rd_bits);

   ship_ram #(.WIDTH(RRPV_ROW_BITS), .DEPTH(NUM_SETS)) u_rrpv (
      .clock(clock), .wr_en(rrpv_we), .wr_addr(rrpv_wa), .wr_data(rrpv_wd),
      .rd_addr(row_ra), .rd_data(rrpv_rd)
   );
   ship_ram #(.WIDTH(SIG_ROW_BITS), .DEPTH(NUM_SETS)) u_sig (
      .clock(clock), .wr_en(sig_we), .wr_addr(rrpv_wa), .wr_data(sig_wd),
      .rd_addr(row_ra), .rd_data(sig_rd)
   );
   ship_ram #(.WIDTH(DET_ROW_BITS), .DEPTH(NUM_SETS)) u_det (
      .clock(clock), .wr_en(det_we), .wr_addr(rrpv_wa), .wr_data(det_wd),
      .rd_addr(row_ra), .rd_data(det_rd_bits)
   );
   ship_ram #(.WIDTH(REUSE_BITS), .DEPTH(TABLE_ENTRIES)) u_reuse (
      .clock(clock), .wr_en(reuse_we), .wr_addr(reuse_wa), .wr_data(reuse_wd),
      .rd_addr(reuse_ra), .rd_data(reuse_rd)
   );

   // stride detector
   logic [ADDR_BITS-1:0] stride;
   logic                 run_same;
   logic [RUN_BITS-1:0]  run_in;
   logic                 stream_in;
   assign stride   = addr_ff - det_rd.prev_addr;
   assign run_same = (det_rd.prev_addr != '0) && (stride != '0)
                     && (stride == det_rd.prev_stride);
   always_comb begin
      if (!run_same) begin
         run_in = '0;
      end else if (det_rd.run < RUN_MAX) begin
         run_in = det_rd.run + RUN_BITS'(1);
      end else begin
         run_in = det_rd.run;
      end
   end
   assign stream_in = (run_in >= thresh_ff);

   // victim scan: lowest invalid way, else first way at the maximum RRPV
   logic                 any_invalid;
   logic [WAY_BITS-1:0]  inv_way;
   logic [RRPV_BITS-1:0] top;
   logic [WAY_BITS-1:0]  top_way;
   logic [RRPV_BITS-1:0] age_add;
   always_comb begin
      any_invalid = 1'b0;
      inv_way     = '0;
      top         = '0;
      top_way     = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (!mask_ff[w]) begin
            any_invalid = 1'b1;
            inv_way     = WAY_BITS'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         top = top | rrpv_rd[w*RRPV_BITS +: RRPV_BITS];
      end
      // OR gives the max only for 2-bit values if refined below
      if (top[1]) begin
         top[0] = 1'b0;
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (rrpv_rd[w*RRPV_BITS +: RRPV_BITS] == RRPV_MAX) begin
               top[0] = 1'b1;
            end
         end
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (rrpv_rd[w*RRPV_BITS +: RRPV_BITS] == top) begin
            top_way = WAY_BITS'(w);
         end
      end
   end
   assign age_add = RRPV_MAX - top;

   // update path
   logic [RRPV_BITS-1:0]  ins_depth;
   logic [SIG_BITS-1:0]   old_sig;
   logic                  miss_plain;
   assign old_sig    = sig_rd[way_ff*SIG_BITS +: SIG_BITS];
   assign miss_plain = !hit_ff && !stream_in;
   always_comb begin
      if (hit_ff) begin
         ins_depth = HIT_DEPTH;
      end else if (stream_in) begin
         ins_depth = RRPV_MAX;
      end else if (reuse_rd >= STRONG_REUSE) begin
         ins_depth = HIT_DEPTH;
      end else begin
         ins_depth = MISS_DEPTH;
      end
   end

   // memory port control
   always_comb begin
      rrpv_we  = 1'b0;
      sig_we   = 1'b0;
      det_we   = 1'b0;
      reuse_we = 1'b0;
      rrpv_wa  = set_ff;
      rrpv_wd  = rrpv_rd;
      sig_wd   = sig_rd;
      det_wd   = det_rd;
      reuse_wa = idx_ff;
      reuse_wd = reuse_rd;
      row_ra   = set_ff;
      reuse_ra = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            rrpv_wa  = clr_ff[SET_BITS-1:0];
            rrpv_we  = (clr_ff < CTR_BITS'(NUM_SETS));
            sig_we   = rrpv_we;
            det_we   = rrpv_we;
            rrpv_wd  = {NUM_WAYS{RRPV_MAX}};
            sig_wd   = '0;
            det_wd   = '0;
            reuse_we = 1'b1;
            reuse_wa = clr_ff;
            reuse_wd = CTR_RESET;
         end
         S_IDLE: begin
            row_ra   = req_set;
            reuse_ra = ctr_index(req_sig, req_set);
         end
         S_LOOK: begin
            // fetch the evicted signature's counter for the decrement step
            reuse_ra = ctr_index(old_sig, set_ff);
            if (mode_ff == MODE_VICTIM) begin
               rrpv_we = !any_invalid && (age_add != '0);
               for (int w = 0; w < NUM_WAYS; w++) begin
                  rrpv_wd[w*RRPV_BITS +: RRPV_BITS] =
                     rrpv_rd[w*RRPV_BITS +: RRPV_BITS] + age_add;
               end
            end else begin
               rrpv_we = 1'b1;
               rrpv_wd[way_ff*RRPV_BITS +: RRPV_BITS] = ins_depth;
               sig_we  = !hit_ff;
               sig_wd[way_ff*SIG_BITS +: SIG_BITS] = sig_ff;
               det_we  = 1'b1;
               det_wd.prev_addr   = addr_ff;
               det_wd.prev_stride = stride;
               det_wd.run         = run_in;
               det_wd.streaming   = stream_in;
               reuse_we = hit_ff && (reuse_rd < CTR_MAX);
               reuse_wd = reuse_rd + REUSE_BITS'(1);
            end
         end
         S_DEC: begin
            reuse_ra = old_idx_ff;
            reuse_wa = old_idx_ff;
            reuse_we = (reuse_rd != '0);
            reuse_wd = reuse_rd - REUSE_BITS'(1);
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         thresh_ff <= THRESH_RESET;
      end else begin
         if (csr_valid) begin
            thresh_ff <= csr_data;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CTR_BITS'(1);
               if (clr_ff == CTR_BITS'(TABLE_ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_LOOK;
                  mode_ff  <= req_tuser[0];
                  set_ff   <= req_set;
                  way_ff   <= req_tdata[14:11];
                  mask_ff  <= req_tdata[30:15];
                  hit_ff   <= req_tdata[31];
                  sig_ff   <= req_sig;
                  addr_ff  <= req_tdata[101:38];
                  idx_ff   <= ctr_index(req_sig, req_set);
               end
            end
            S_LOOK: begin
               old_idx_ff <= ctr_index(old_sig, set_ff);
               if (mode_ff == MODE_VICTIM) begin
                  victim_ff <= any_invalid ? inv_way : top_way;
                  stream_ff <= det_rd.streaming;
                  state_ff  <= S_OUT;
               end else begin
                  victim_ff <= '0;
                  stream_ff <= stream_in;
                  state_ff  <= miss_plain ? S_DEC : S_OUT;
               end
            end
            S_DEC: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {3'b000, stream_ff, victim_ff};
   assign csr_ready  = 1'b1;

   // one request at a time: never ready while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready right after an accepted transfer");

   a_update_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && mode_ff == MODE_UPDATE) |-> (rsp_tdata[3:0] == '0))
      else $error("update response carries a nonzero victim way");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!req_tready && !rsp_tvalid))
      else $error("channel active during clearing pass");

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import ship_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ship_stream_rrip_replacement u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   typedef struct {
      logic                mode;
      logic [10:0]         set_index;
      logic [3:0]          way;
      logic [15:0]         valid_mask;
      logic                hit;
      logic [5:0]          sig;
      logic [63:0]         address;
   } access_type;

   typedef struct {
      logic [3:0] victim;
      logic       streaming;
   } answer_type;

   // shadow replacement state
   logic [1:0]  rrpv_sh [NUM_SETS][NUM_WAYS];
   logic [5:0]  sig_sh [NUM_SETS][NUM_WAYS];
   logic [1:0]  reuse_sh [TABLE_ENTRIES];
   logic [63:0] last_addr_sh [NUM_SETS];
   logic [63:0] last_stride_sh [NUM_SETS];
   logic [4:0]  run_sh [NUM_SETS];
   logic        stream_sh [NUM_SETS];
   logic [4:0]  threshold_sh;

   answer_type answers_q[$];
   int      error_count = 0;
   int      rsp_count = 0;
   int      victim_count = 0;
   int      update_count = 0;
   int      idle_cycles = 0;
   bit      hold_rsp = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (rsp %0d)", what, got, want, rsp_count);
      error_count++;
   endtask

   function automatic logic [11:0] reuse_slot(logic [5:0] s, logic [10:0] set_i);
      return {6'd0, s} ^ {1'b0, set_i};
   endfunction

   function automatic void shadow_reset();
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_sh[s][w] = 2'd3;
            sig_sh[s][w] = '0;
         end
         last_addr_sh[s] = '0;
         last_stride_sh[s] = '0;
         run_sh[s] = '0;
         stream_sh[s] = 1'b0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) reuse_sh[i] = 2'd1;
      threshold_sh = 5'd8;
   endfunction

   // computes the answer for one access and advances the shadow state
   function automatic answer_type replace_predict(access_type a);
      answer_type  r;
      logic [63:0] stride;
      logic [1:0]  top;
      logic [11:0] idx, old_idx;
      int          s, w;
      bit          found;
      s = a.set_index;
      w = a.way;
      r.victim = '0;
      found = 1'b0;
      if (a.mode == MODE_VICTIM) begin
         for (int i = 0; i < NUM_WAYS; i++)
            if (!found && !a.valid_mask[i]) begin
               r.victim = 4'(i);
               found = 1'b1;
            end
         if (!found) begin
            top = '0;
            for (int i = 0; i < NUM_WAYS; i++)
               if (rrpv_sh[s][i] > top) begin
                  top = rrpv_sh[s][i];
                  r.victim = 4'(i);
               end
            if (top < 2'd3)
               for (int i = 0; i < NUM_WAYS; i++)
                  rrpv_sh[s][i] = rrpv_sh[s][i] + (2'd3 - top);
         end
      end else begin
         stride = a.address - last_addr_sh[s];
         if (last_addr_sh[s] != 0 && stride != 0 && stride == last_stride_sh[s]) begin
            if (run_sh[s] < 5'd31) run_sh[s]++;
         end else begin
            run_sh[s] = '0;
         end
         last_stride_sh[s] = stride;
         last_addr_sh[s] = a.address;
         stream_sh[s] = run_sh[s] >= threshold_sh;
         idx = reuse_slot(a.sig, a.set_index);
         if (a.hit) begin
            rrpv_sh[s][w] = 2'd0;
            if (reuse_sh[idx] < 2'd3) reuse_sh[idx]++;
         end else if (stream_sh[s]) begin
            rrpv_sh[s][w] = 2'd3;
            sig_sh[s][w] = a.sig;
         end else begin
            old_idx = reuse_slot(sig_sh[s][w], a.set_index);
            rrpv_sh[s][w] = (reuse_sh[idx] >= 2'd2) ? 2'd0 : 2'd2;
            sig_sh[s][w] = a.sig;
            if (reuse_sh[old_idx] > 0) reuse_sh[old_idx]--;
         end
      end
      r.streaming = stream_sh[s];
      return r;
   endfunction

   // one transfer on the request side; expectation queued at acceptance.
   // tvalid stays up after a transfer and drops only when a gap follows.
   task automatic send_access(access_type a, input bit typed, input answer_type want);
      answer_type p;
      int         gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= a.mode;
      req_tdata  <= {2'b00, a.address, a.sig, a.hit, a.valid_mask, a.way, a.set_index};
      do @(posedge clock); while (!req_tready);
      p = replace_predict(a);
      if (typed && (p.victim != want.victim || p.streaming != want.streaming))
         $display("note: table row disagrees with shadow state");
      answers_q.push_back(typed ? want : p);
      if (a.mode == MODE_VICTIM) victim_count++; else update_count++;
   endtask

   task automatic write_threshold(input logic [4:0] v);
      req_tvalid <= 1'b0;
      while (answers_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      threshold_sh = v;
      csr_valid <= 1'b0;
   endtask

   function automatic access_type random_access(int set_span, bit streaming_run,
                                             ref logic [63:0] base, input logic [63:0] step);
      access_type a;
      a.mode = 1'($urandom_range(0, 1));
      a.set_index = 11'($urandom_range(0, set_span));
      if ($urandom_range(0, 20) == 0) a.set_index = 11'($urandom_range(0, 2047));
      a.way = 4'($urandom_range(0, 15));
      a.valid_mask = ($urandom_range(0, 2) == 0) ? 16'(($urandom() | $urandom()) &
                     ~(16'h1 << $urandom_range(0, 15))) : 16'hffff;
      if ($urandom_range(0, 5) == 0) a.valid_mask = 16'($urandom());
      a.hit = 1'($urandom_range(0, 1));
      a.sig = 6'($urandom_range(0, 63));
      if (streaming_run) begin
         base = base + step;
         a.address = base;
      end else begin
         a.address = {$urandom(), $urandom()};
      end
      return a;
   endfunction

   // receiver: random stalls, plus one long hold-off to back the block up
   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_tready && rsp_tvalid) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // checker: compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_type w;
         rsp_count <= rsp_count + 1;
         if (answers_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, -1);
         end else begin
            w = answers_q.pop_front();
            if (rsp_tdata[3:0] != w.victim)
               report_mismatch("victim_way", rsp_tdata[3:0], w.victim);
            if (rsp_tdata[4] != w.streaming)
               report_mismatch("set_streaming", rsp_tdata[4], w.streaming);
         end
      end
   end

   // watchdog: covers the clearing pass and the long hold-off
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("ship_stream_rrip_replacement regression: fail");
         $finish;
      end
   end

   typedef struct {
      access_type a;
      bit         typed;
      answer_type want;
   } row_type;

   initial begin
      row_type     rows[$];
      row_type     r;
      logic [63:0] base, step;
      int          span;
      bit          run_mode;
      logic [4:0]  thr_list[5];

      thr_list = '{5'd0, 5'd31, 5'd3, 5'd8, 5'd1};
      shadow_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // after reset: all-valid set yields way 0; empty way picked; extremes
      r.typed = 1'b1;
      r.a = '{MODE_VICTIM, 11'd0, 4'd0, 16'hffff, 1'b0, 6'd0, 64'd0};
      r.want = '{4'd0, 1'b0}; rows.push_back(r);
      r.a = '{MODE_VICTIM, 11'd2047, 4'd0, 16'h7fff, 1'b0, 6'd0, 64'd0};
      r.want = '{4'd15, 1'b0}; rows.push_back(r);
      r.a = '{MODE_VICTIM, 11'd5, 4'd0, 16'h0000, 1'b0, 6'd0, 64'd0};
      r.want = '{4'd0, 1'b0}; rows.push_back(r);
      r.a = '{MODE_VICTIM, 11'd5, 4'd0, 16'hfeff, 1'b0, 6'd0, 64'd0};
      r.want = '{4'd8, 1'b0}; rows.push_back(r);
      r.typed = 1'b0;
      // hits, misses, max address, max signature, victim scan
      r.a = '{MODE_UPDATE, 11'd7, 4'd15, 16'h0, 1'b1, 6'd63, 64'hffff_ffff_ffff_ffff};
      rows.push_back(r);
      r.a = '{MODE_UPDATE, 11'd7, 4'd3, 16'h0, 1'b0, 6'd63, 64'h0};
      rows.push_back(r);
      r.a = '{MODE_UPDATE, 11'd7, 4'd0, 16'hffff, 1'b0, 6'd1, 64'h40};
      rows.push_back(r);
      r.a = '{MODE_VICTIM, 11'd7, 4'd0, 16'hffff, 1'b0, 6'd0, 64'h0};
      rows.push_back(r);
      // a stride run long enough to stream, then a streaming miss and victim
      for (int i = 1; i <= 12; i++) begin
         r.a = '{MODE_UPDATE, 11'd9, 4'(i), 16'h0, 1'b0, 6'(i), 64'(i * 64)};
         rows.push_back(r);
      end
      r.a = '{MODE_VICTIM, 11'd9, 4'd0, 16'hffff, 1'b0, 6'd0, 64'h0};
      rows.push_back(r);
      foreach (rows[i]) send_access(rows[i].a, rows[i].typed, rows[i].want);

      // random phases across several thresholds; long receiver hold-off in phase 1
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(thr_list[ph]);
         if (ph == 1) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 300; n++) begin
            if (n % 30 == 0) begin
               span = ($urandom_range(0, 1) == 0) ? 3 : 31;
               run_mode = $urandom_range(0, 3) != 0;
               base = {$urandom(), $urandom()};
               step = ($urandom_range(0, 4) == 0) ? {$urandom(), $urandom()} :
                      64'($urandom_range(1, 256));
            end
            send_access(random_access(run_mode ? 0 : span, run_mode, base, step),
                        1'b0, '{4'd0, 1'b0});
         end
      end
      req_tvalid <= 1'b0;

      while (answers_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d victim requests and %0d updates, %0d responses checked",
               victim_count, update_count, rsp_count);
      $display("thresholds 0, 31, 3, 8, 1; stride runs, hits, fills and aging exercised");
      if (error_count == 0 && answers_q.size() == 0)
         $display("ship_stream_rrip_replacement regression: pass");
      else
         $display("ship_stream_rrip_replacement regression: fail");
      $finish;
   end

endmodule
